/* hdl/grid_maze_bfs_path_top_assert.svh */
// Assertion macros for the maze search block.
`ifndef GRID_MAZE_BFS_PATH_TOP_ASSERT_SVH
`define GRID_MAZE_BFS_PATH_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define GMB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gmb assertion failed");
`define GMB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("gmb assertion failed");
`else
`define GMB_ASSERT(lbl, prop)
`define GMB_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* hdl/gmb_pkg.sv */
package gmb_pkg;
  localparam logic [7:0] CH_WALL   = 8'h23;
  localparam logic [7:0] CH_START  = 8'h41;
  localparam logic [7:0] CH_TARGET = 8'h42;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_STEP    = 1'b1;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef logic [1:0] dir_t;
  localparam dir_t DIR_RIGHT = 2'd0;
  localparam dir_t DIR_LEFT  = 2'd1;
  localparam dir_t DIR_DOWN  = 2'd2;
  localparam dir_t DIR_UP    = 2'd3;

  // one maze cell in the cell memory
  typedef struct packed {
    logic wall;
    logic seen;
    dir_t par;
  } cell_t;

  localparam int PLEN_MAX = 4095;
endpackage

/* hdl/gmb_ram.sv */
module gmb_ram #(
  parameter int DW = 4,
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [(1 << AW)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/grid_maze_bfs_path_top.sv */
// Grid maze shortest path by breadth-first search.
// Input beats: in_tuser[0] selects the function. Load beats (0) carry one maze
// byte each in row-major order ('#' wall, 'A' start, 'B' target). Step beats (1)
// ask for one move of the last path by index.
// The load beat that completes the grid starts the search and yields one
// summary beat (reachable, path length).
// Search steps: split the start position into row and column by repeated
// subtraction, then dequeue each cell and probe its four directions in turn,
// reading the cell memory (single-port read) for each in-grid neighbor, then
// trace back from the target to count the path moves, then trace back again
// to write the path out.
// A step beat runs S_SQ, then S_EMIT raises out_tvalid when the output is free.
// One item is in work at a time; in_tready is high while the engine is idle.
// The result sits in an output register: the engine may idle again and take
// a load beat while a result waits, but a beat that produces a result holds
// until the output register frees up.
// Reset clears the counters and flags, sets both geometry registers to 64, and
// leaves memories as they are (every grid cell is written on load). User rule:
// configuration writes (cfg_we/cfg_idx/cfg_wdata) only while idle; unchecked.
module grid_maze_bfs_path_top #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // cell_char[7:0], step_index[19:8], zero pad
  input  logic [0:0]  in_tuser,   // func[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // reachable[0], path_length[12:1],
                                  // step_dir[14:13], step_valid[15]
  output logic [0:0]  out_tuser   // reply_kind[0]
);
  import gmb_pkg::*;

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int TW    = $clog2(CELLS + 1);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RNW   = $clog2(MAX_ROWS + 1);
  localparam int CNW   = $clog2(MAX_COLS + 1);
  localparam int QW    = RW + CW + AW;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_SRCH = 5'd1;
  localparam logic [4:0] S_DIV  = 5'd2;
  localparam logic [4:0] S_SEED = 5'd3;
  localparam logic [4:0] S_QRD  = 5'd4;
  localparam logic [4:0] S_QWT  = 5'd5;
  localparam logic [4:0] S_PRB  = 5'd6;
  localparam logic [4:0] S_CHK  = 5'd7;
  localparam logic [4:0] S_TRD  = 5'd8;
  localparam logic [4:0] S_TCK  = 5'd9;
  localparam logic [4:0] S_TR1  = 5'd10;
  localparam logic [4:0] S_TR2  = 5'd11;
  localparam logic [4:0] S_WR1  = 5'd12;
  localparam logic [4:0] S_WR2  = 5'd13;
  localparam logic [4:0] S_SQ   = 5'd14;
  localparam logic [4:0] S_EMIT = 5'd15;

  // geometry
  logic [6:0] rows_cfg_r, cols_cfg_r;
  logic [RNW-1:0] rows_eff;
  logic [CNW-1:0] cols_eff;
  logic [TW-1:0]  total;

  always_comb begin
    if (rows_cfg_r == 7'd0) begin
      rows_eff = RNW'(1);
    end else if (32'(rows_cfg_r) > MAX_ROWS) begin
      rows_eff = RNW'(MAX_ROWS);
    end else begin
      rows_eff = RNW'(rows_cfg_r);
    end
    if (cols_cfg_r == 7'd0) begin
      cols_eff = CNW'(1);
    end else if (32'(cols_cfg_r) > MAX_COLS) begin
      cols_eff = CNW'(MAX_COLS);
    end else begin
      cols_eff = CNW'(cols_cfg_r);
    end
  end
  assign total = TW'(rows_eff) * TW'(cols_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= 7'd64;
      cols_cfg_r <= 7'd64;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_ROWS) begin
        rows_cfg_r <= cfg_wdata;
      end
      if (cfg_idx == CFG_COLS) begin
        cols_cfg_r <= cfg_wdata;
      end
    end
  end

  // memories
  logic          cm_we;
  logic [AW-1:0] cm_waddr, cm_raddr;
  cell_t         cm_wdata, cm_rdata;
  logic          qm_we;
  logic [AW-1:0] qm_waddr, qm_raddr;
  logic [QW-1:0] qm_wdata, qm_rdata;

  gmb_ram #(.DW($bits(cell_t)), .AW(AW)) u_cell_ram (
    .clk(clk), .we(cm_we), .waddr(cm_waddr), .wdata(cm_wdata),
    .raddr(cm_raddr), .rdata(cm_rdata)
  );

  // frontier queue; holds the path moves once the search is done
  gmb_ram #(.DW(QW), .AW(AW)) u_queue_ram (
    .clk(clk), .we(qm_we), .waddr(qm_waddr), .wdata(qm_wdata),
    .raddr(qm_raddr), .rdata(qm_rdata)
  );

  // control state
  logic [4:0]    st_r, st_nxt;
  logic [TW-1:0] loaded_r, loaded_nxt;
  logic [AW-1:0] start_r, start_nxt, target_r, target_nxt;
  logic          sseen_r, sseen_nxt, tseen_r, tseen_nxt, reach_r, reach_nxt;
  logic [TW-1:0] mc_r, mc_nxt;
  logic [AW-1:0] rem_r, rem_nxt;
  logic [RW-1:0] srow_r, srow_nxt;
  logic [TW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [RW-1:0] urow_r, urow_nxt, nrow_r, nrow_nxt;
  logic [CW-1:0] ucol_r, ucol_nxt, ncol_r, ncol_nxt;
  logic [AW-1:0] ulin_r, ulin_nxt, nlin_r, nlin_nxt;
  dir_t          d_r, d_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [TW-1:0] len_r, len_nxt;
  logic [11:0]   idx_r, idx_nxt;
  logic          res_kind_r, res_kind_nxt, res_ok_r, res_ok_nxt;
  dir_t          res_dir_r, res_dir_nxt;
  logic          ov_r, ov_nxt;
  logic [15:0]   od_r, od_nxt;
  logic          ok_r, ok_nxt;

  logic [7:0]    ch;
  logic [11:0]   plen;
  logic [AW-1:0] prev_pos;
  logic          in_acc;

  assign ch     = in_tdata[7:0];
  assign in_acc = in_tvalid && in_tready;
  assign plen   = (32'(mc_r) > PLEN_MAX) ? 12'(PLEN_MAX) : 12'(mc_r);
  assign in_tready = (st_r == S_IDLE);

  // step back against the recorded entry move
  always_comb begin
    case (cm_rdata.par)
      DIR_RIGHT: prev_pos = pos_r - AW'(1);
      DIR_LEFT:  prev_pos = pos_r + AW'(1);
      DIR_DOWN:  prev_pos = pos_r - AW'(cols_eff);
      DIR_UP:    prev_pos = pos_r + AW'(cols_eff);
      default:   prev_pos = pos_r;
    endcase
  end

  always_comb begin
    logic inb;
    logic [TW-1:0] ld1;
    st_nxt = st_r;       loaded_nxt = loaded_r;
    start_nxt = start_r; target_nxt = target_r;
    sseen_nxt = sseen_r; tseen_nxt = tseen_r; reach_nxt = reach_r;
    mc_nxt = mc_r;       rem_nxt = rem_r;       srow_nxt = srow_r;
    head_nxt = head_r;   tail_nxt = tail_r;
    urow_nxt = urow_r;   ucol_nxt = ucol_r;     ulin_nxt = ulin_r;
    nrow_nxt = nrow_r;   ncol_nxt = ncol_r;     nlin_nxt = nlin_r;
    d_nxt = d_r;         pos_nxt = pos_r;       len_nxt = len_r;
    idx_nxt = idx_r;     ok_nxt = ok_r;
    res_kind_nxt = res_kind_r; res_ok_nxt = res_ok_r; res_dir_nxt = res_dir_r;
    ov_nxt = ov_r && !out_tready;
    od_nxt = od_r;
    cm_we = 1'b0; cm_waddr = loaded_r[AW-1:0]; cm_wdata = '0;
    cm_raddr = pos_r;
    qm_we = 1'b0; qm_waddr = tail_r[AW-1:0]; qm_wdata = '0;
    qm_raddr = head_r[AW-1:0];
    inb = 1'b0;
    ld1 = loaded_r + TW'(1);

    case (st_r)
      S_IDLE: begin
        qm_raddr = AW'(in_tdata[19:8]);
        if (in_acc && in_tuser[0] == FUNC_STEP) begin
          idx_nxt = in_tdata[19:8];
          ok_nxt  = reach_r && (32'(in_tdata[19:8]) < 32'(mc_r));
          st_nxt  = S_SQ;
        end else if (in_acc) begin
          if (loaded_r == '0) begin
            sseen_nxt = 1'b0; tseen_nxt = 1'b0; reach_nxt = 1'b0; mc_nxt = '0;
          end
          if (loaded_r < total) begin
            cm_we    = 1'b1;
            cm_wdata = '{wall: (ch == CH_WALL), seen: 1'b0, par: DIR_RIGHT};
            if (ch == CH_START) begin
              start_nxt = loaded_r[AW-1:0]; sseen_nxt = 1'b1;
            end
            if (ch == CH_TARGET) begin
              target_nxt = loaded_r[AW-1:0]; tseen_nxt = 1'b1;
            end
          end
          if (ld1 >= total) begin
            loaded_nxt = '0;
            st_nxt = S_SRCH;
          end else begin
            loaded_nxt = ld1;
          end
        end
      end
      S_SRCH: begin
        reach_nxt = 1'b0; mc_nxt = '0;
        res_kind_nxt = KIND_SUMMARY; res_ok_nxt = 1'b0; res_dir_nxt = DIR_RIGHT;
        if (!sseen_r || !tseen_r || TW'(start_r) >= total || TW'(target_r) >= total) begin
          st_nxt = S_EMIT;
        end else begin
          rem_nxt = start_r; srow_nxt = '0; st_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // split the start index into row and column
        if (rem_r >= AW'(cols_eff)) begin
          rem_nxt  = rem_r - AW'(cols_eff);
          srow_nxt = srow_r + RW'(1);
        end else begin
          st_nxt = S_SEED;
        end
      end
      S_SEED: begin
        cm_we = 1'b1; cm_waddr = start_r;
        cm_wdata = '{wall: 1'b0, seen: 1'b1, par: DIR_RIGHT};
        qm_we = 1'b1; qm_waddr = '0;
        qm_wdata = {srow_r, CW'(rem_r), start_r};
        head_nxt = '0; tail_nxt = TW'(1);
        st_nxt = S_QRD;
      end
      S_QRD: begin
        if (head_r == tail_r) begin
          st_nxt = S_TRD;
        end else begin
          head_nxt = head_r + TW'(1);
          st_nxt = S_QWT;
        end
      end
      S_QWT: begin
        {urow_nxt, ucol_nxt, ulin_nxt} = qm_rdata;
        d_nxt = DIR_RIGHT;
        st_nxt = S_PRB;
      end
      S_PRB: begin
        nrow_nxt = urow_r; ncol_nxt = ucol_r;
        case (d_r)
          DIR_RIGHT: begin
            inb = (CNW'(ucol_r) + CNW'(1)) < cols_eff;
            ncol_nxt = ucol_r + CW'(1); nlin_nxt = ulin_r + AW'(1);
          end
          DIR_LEFT: begin
            inb = (ucol_r != '0);
            ncol_nxt = ucol_r - CW'(1); nlin_nxt = ulin_r - AW'(1);
          end
          DIR_DOWN: begin
            inb = (RNW'(urow_r) + RNW'(1)) < rows_eff;
            nrow_nxt = urow_r + RW'(1); nlin_nxt = ulin_r + AW'(cols_eff);
          end
          DIR_UP: begin
            inb = (urow_r != '0);
            nrow_nxt = urow_r - RW'(1); nlin_nxt = ulin_r - AW'(cols_eff);
          end
          default: begin
            inb = 1'b0; nlin_nxt = ulin_r;
          end
        endcase
        cm_raddr = nlin_nxt;
        if (inb) begin
          st_nxt = S_CHK;
        end else if (d_r == DIR_UP) begin
          st_nxt = S_QRD;
        end else begin
          d_nxt = d_r + dir_t'(1);
        end
      end
      S_CHK: begin
        if (!cm_rdata.seen && !cm_rdata.wall) begin
          cm_we = 1'b1; cm_waddr = nlin_r;
          cm_wdata = '{wall: 1'b0, seen: 1'b1, par: d_r};
          qm_we = 1'b1;
          qm_wdata = {nrow_r, ncol_r, nlin_r};
          tail_nxt = tail_r + TW'(1);
        end
        if (d_r == DIR_UP) begin
          st_nxt = S_QRD;
        end else begin
          d_nxt = d_r + dir_t'(1);
          st_nxt = S_PRB;
        end
      end
      S_TRD: begin
        cm_raddr = target_r;
        st_nxt = S_TCK;
      end
      S_TCK: begin
        if (!cm_rdata.seen) begin
          st_nxt = S_EMIT;
        end else begin
          pos_nxt = target_r; len_nxt = '0; st_nxt = S_TR1;
        end
      end
      S_TR1: begin
        // count the moves back to the start
        cm_raddr = pos_r;
        if (pos_r == start_r) begin
          pos_nxt = target_r;
          mc_nxt  = len_r;
          st_nxt  = S_WR1;
        end else begin
          st_nxt = S_TR2;
        end
      end
      S_TR2: begin
        pos_nxt = prev_pos;
        len_nxt = len_r + TW'(1);
        st_nxt  = S_TR1;
      end
      S_WR1: begin
        // write the moves out, last move first
        cm_raddr = pos_r;
        if (len_r == '0) begin
          reach_nxt = 1'b1;
          st_nxt = S_EMIT;
        end else begin
          st_nxt = S_WR2;
        end
      end
      S_WR2: begin
        qm_we = 1'b1;
        qm_waddr = AW'(len_r - TW'(1));
        qm_wdata = QW'(cm_rdata.par);
        pos_nxt = prev_pos;
        len_nxt = len_r - TW'(1);
        st_nxt = S_WR1;
      end
      S_SQ: begin
        res_kind_nxt = KIND_STEP;
        res_ok_nxt   = ok_r;
        res_dir_nxt  = ok_r ? dir_t'(qm_rdata[1:0]) : DIR_RIGHT;
        st_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          od_nxt = {res_ok_r, res_dir_r, plen, reach_r};
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  logic ok_kind_r, ok_kind_nxt;
  assign ok_kind_nxt = (st_r == S_EMIT && (!ov_r || out_tready)) ? res_kind_r : ok_kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; loaded_r <= '0; start_r <= '0; target_r <= '0;
      sseen_r <= 1'b0; tseen_r <= 1'b0; reach_r <= 1'b0; mc_r <= '0;
      head_r <= '0; tail_r <= '0; len_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; loaded_r <= loaded_nxt; start_r <= start_nxt;
      target_r <= target_nxt; sseen_r <= sseen_nxt; tseen_r <= tseen_nxt;
      reach_r <= reach_nxt; mc_r <= mc_nxt; head_r <= head_nxt;
      tail_r <= tail_nxt; len_r <= len_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt; srow_r <= srow_nxt;
    urow_r <= urow_nxt; ucol_r <= ucol_nxt; ulin_r <= ulin_nxt;
    nrow_r <= nrow_nxt; ncol_r <= ncol_nxt; nlin_r <= nlin_nxt;
    d_r <= d_nxt; pos_r <= pos_nxt; idx_r <= idx_nxt; ok_r <= ok_nxt;
    res_kind_r <= res_kind_nxt; res_ok_r <= res_ok_nxt; res_dir_r <= res_dir_nxt;
    od_r <= od_nxt; ok_kind_r <= ok_kind_nxt;
  end

  assign out_tvalid   = ov_r;
  assign out_tdata    = od_r;
  assign out_tuser[0] = ok_kind_r;

  `include "grid_maze_bfs_path_top_assert.svh"

  `GMB_ASSERT(a_head_le_tail, (st_r == S_QRD) |-> (head_r <= tail_r))
  `GMB_ASSERT(a_tail_in_grid, (st_r == S_CHK) |-> (tail_r <= total))
  `GMB_ASSERT(a_trace_bounded, (st_r == S_TR2) |-> (len_r < total))
  `GMB_ASSERT(a_step_ok_reach, (st_r == S_SQ && ok_r) |-> (reach_r && (32'(idx_r) < 32'(mc_r))))
endmodule
